>>> rtl/ahpt_pkg.sv
// Shared constants and control types of the argument histogram peak tracker.
`default_nettype none

package ahpt_pkg;

    localparam int BIN_W     = 8;
    localparam int BINS      = 1 << BIN_W;
    localparam int DATA_W    = 32;
    localparam int OFF_W     = DATA_W + 1;
    localparam int REM_W     = DATA_W + 1;
    localparam int SPAN_W    = DATA_W + 2;
    localparam int DVD_W     = DATA_W + BIN_W;
    localparam int DIV_STEPS = DVD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_RANGE_LOW  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_RANGE_HIGH = 1'b1;

    localparam logic [DATA_W-1:0] RANGE_LOW_RST  = 32'sd0;
    localparam logic [DATA_W-1:0] RANGE_HIGH_RST = 32'sd255;
    localparam logic [DATA_W-1:0] COUNT_MAX      = '1;

    typedef struct packed {
        logic load_item;
        logic load_peak;
        logic step;
        logic mem_rd;
        logic update;
        logic peak_set;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic out_busy;
    } t_status;

endpackage

`default_nettype wire

>>> rtl/argument_histogram_peak_tracker.sv
// Top level of the argument histogram peak tracker.
// Usage: each request on the input channel carries one signed sample. The
// sample is placed in one of 256 bins by an exact integer division against
// the configured range, that bin's count is incremented with saturation, and
// one result request is issued with the bin, its count and the current peak.
// The input request is taken while the input valid is high and the input
// stall is low; the result is taken while the output valid is high and the
// output stall is low.
// A sample inside or below the range, or under an empty range, has only
// its bin's quotient bits resolved; a sample at or above the top of the
// range runs the bin divider over its whole dividend. The divider resolves
// one quotient bit per cycle; the count store is then read and written.
// Only one sample is in work at a time, so a new sample is not accepted
// until the count update of the last one is done. A finished result waits
// in the output register while the receiver stalls, and the next sample is
// accepted and binned meanwhile; its count update waits until it frees.
// A write to a range register while no sample is in work restarts a pass
// that rebins the peak sample and reloads the peak count; input stays stalled.
// Reset is synchronous and clears all counts at once, sets the range to
// 0 through 255 and places the peak on bin 0 with a count of zero.
`default_nettype none

module argument_histogram_peak_tracker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic signed [ahpt_pkg::DATA_W-1:0] i_sample,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [ahpt_pkg::BIN_W-1:0]              o_bin_index,
    output logic [ahpt_pkg::DATA_W-1:0]             o_bin_count,
    output logic [ahpt_pkg::BIN_W-1:0]              o_peak_bin,
    output logic [ahpt_pkg::DATA_W-1:0]             o_peak_count,
    output logic signed [ahpt_pkg::DATA_W-1:0]      o_peak_sample,
    input  wire logic                               i_cfg_we,
    input  wire logic [ahpt_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [ahpt_pkg::DATA_W-1:0]        i_cfg_data
);

    import ahpt_pkg::*;

    t_cmd    cmd;
    t_status status;

    ahpt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_cfg_we  (i_cfg_we),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_in_stall(o_in_stall)
    );

    ahpt_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_sample     (i_sample),
        .i_out_stall  (i_out_stall),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .o_bin_index  (o_bin_index),
        .o_bin_count  (o_bin_count),
        .o_peak_bin   (o_peak_bin),
        .o_peak_count (o_peak_count),
        .o_peak_sample(o_peak_sample)
    );

endmodule

`default_nettype wire

>>> rtl/ahpt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ahpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/ahpt_ctrl.sv
// Control state machine that sequences binning, count update and peak reload.
`default_nettype none

module ahpt_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_cfg_we,
    input  wire ahpt_pkg::t_status i_status,
    output ahpt_pkg::t_cmd        o_cmd,
    output logic                  o_in_stall
);

    import ahpt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_UPD,
        S_PWAIT,
        S_PLOAD,
        S_PDIV,
        S_PREAD,
        S_PSET
    } t_state;

    t_state r_state;

    always_comb begin
        o_cmd           = '0;
        o_cmd.load_item = (r_state == S_IDLE) && i_in_valid && !i_cfg_we;
        o_cmd.load_peak = (r_state == S_PLOAD);
        o_cmd.step      = (r_state == S_DIV) || (r_state == S_PDIV);
        o_cmd.mem_rd    = (r_state == S_READ) || (r_state == S_PREAD);
        o_cmd.update    = (r_state == S_UPD) && !i_status.out_busy;
        o_cmd.peak_set  = (r_state == S_PSET);
        o_in_stall      = (r_state != S_IDLE) || i_cfg_we;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_we) begin
                        r_state <= S_PWAIT;
                    end else if (i_in_valid) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (i_status.div_last) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (!i_status.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                S_PWAIT: begin
                    r_state <= i_cfg_we ? S_PWAIT : S_PLOAD;
                end
                S_PLOAD: begin
                    r_state <= i_cfg_we ? S_PWAIT : S_PDIV;
                end
                S_PDIV: begin
                    if (i_cfg_we) begin
                        r_state <= S_PWAIT;
                    end else if (i_status.div_last) begin
                        r_state <= S_PREAD;
                    end
                end
                S_PREAD: begin
                    r_state <= i_cfg_we ? S_PWAIT : S_PSET;
                end
                S_PSET: begin
                    r_state <= i_cfg_we ? S_PWAIT : S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/ahpt_dp.sv
// Datapath: range registers, bin divider, count store and peak registers.
`default_nettype none

module ahpt_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire ahpt_pkg::t_cmd                     i_cmd,
    output ahpt_pkg::t_status                       o_status,
    input  wire logic signed [ahpt_pkg::DATA_W-1:0] i_sample,
    input  wire logic                               i_out_stall,
    input  wire logic                               i_cfg_we,
    input  wire logic [ahpt_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [ahpt_pkg::DATA_W-1:0]        i_cfg_data,
    output logic                                    o_out_valid,
    output logic [ahpt_pkg::BIN_W-1:0]              o_bin_index,
    output logic [ahpt_pkg::DATA_W-1:0]             o_bin_count,
    output logic [ahpt_pkg::BIN_W-1:0]              o_peak_bin,
    output logic [ahpt_pkg::DATA_W-1:0]             o_peak_count,
    output logic signed [ahpt_pkg::DATA_W-1:0]      o_peak_sample
);

    import ahpt_pkg::*;

    logic [DATA_W-1:0] r_low;
    logic [DATA_W-1:0] r_high;
    logic [SPAN_W-1:0] r_span;

    logic [REM_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_dvd;
    logic [BIN_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_zero;
    logic [DATA_W-1:0] r_sample;

    logic [BINS-1:0]   r_valid;
    logic              r_rd_valid;
    logic [DATA_W-1:0] rd_data;

    logic [BIN_W-1:0]  r_peak_bin;
    logic [DATA_W-1:0] r_peak_count;
    logic [DATA_W-1:0] r_peak_sample;

    logic [DATA_W-1:0] src;
    logic [OFF_W-1:0]  off;
    logic              span_bad;
    logic              below;
    logic [REM_W:0]    trial;
    logic [REM_W:0]    diff;
    logic              ge;
    logic [BIN_W-1:0]  bin;
    logic [DATA_W-1:0] cnt_old;
    logic [DATA_W-1:0] cnt_new;
    logic [DATA_W-1:0] item_sample;

    always_comb begin
        item_sample = i_sample;
        src      = i_cmd.load_peak ? r_peak_sample : item_sample;
        off      = {src[DATA_W-1], src} - {r_low[DATA_W-1], r_low};
        span_bad = r_span[SPAN_W-1] || (r_span == '0);
        below    = {1'b0, off} < r_span;
        trial    = {r_rem, r_dvd[DVD_W-1]};
        diff     = trial - r_span[REM_W:0];
        ge       = trial >= r_span[REM_W:0];
        bin      = r_zero ? '0 : r_quo;
        cnt_old  = r_rd_valid ? rd_data : '0;
        cnt_new  = (cnt_old == COUNT_MAX) ? cnt_old : cnt_old + 1'b1;
    end

    assign o_status.div_last = (r_cnt == CNT_W'(1));
    assign o_status.out_busy = o_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= RANGE_LOW_RST;
            r_high <= RANGE_HIGH_RST;
            r_span <= SPAN_W'(RANGE_HIGH_RST) + 1'b1 - SPAN_W'(RANGE_LOW_RST);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_RANGE_LOW:  r_low  <= i_cfg_data;
                    REG_RANGE_HIGH: r_high <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_span <= {{2{r_high[DATA_W-1]}}, r_high} + 1'b1
                      - {{2{r_low[DATA_W-1]}}, r_low};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item || i_cmd.load_peak) begin
            r_zero <= off[OFF_W-1] || span_bad;
            r_quo  <= '0;
            if (i_cmd.load_item) begin
                r_sample <= item_sample;
            end
            if (below || off[OFF_W-1] || span_bad) begin
                r_rem <= {1'b0, off[DATA_W-1:0]};
                r_dvd <= '0;
                r_cnt <= CNT_W'(BIN_W);
            end else begin
                r_rem <= '0;
                r_dvd <= {off[DATA_W-1:0], {BIN_W{1'b0}}};
                r_cnt <= CNT_W'(DIV_STEPS);
            end
        end else if (i_cmd.step) begin
            r_rem <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
            r_dvd <= r_dvd << 1;
            r_quo <= {r_quo[BIN_W-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    ahpt_ram #(
        .WIDTH(DATA_W),
        .DEPTH(BINS)
    ) u_counts (
        .i_clk  (i_clk),
        .i_we   (i_cmd.update),
        .i_waddr(bin),
        .i_wdata(cnt_new),
        .i_re   (i_cmd.mem_rd),
        .i_raddr(bin),
        .o_rdata(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_peak_bin    <= '0;
            r_peak_count  <= '0;
            r_peak_sample <= '0;
            o_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.mem_rd) begin
                r_rd_valid <= r_valid[bin];
            end
            if (i_cmd.peak_set) begin
                r_peak_bin   <= bin;
                r_peak_count <= cnt_old;
            end
            if (i_cmd.update) begin
                r_valid[bin] <= 1'b1;
                o_out_valid  <= 1'b1;
                o_bin_index  <= bin;
                o_bin_count  <= cnt_new;
                if (bin == r_peak_bin) begin
                    r_peak_count  <= cnt_new;
                    o_peak_bin    <= r_peak_bin;
                    o_peak_count  <= cnt_new;
                    o_peak_sample <= r_peak_sample;
                end else if (cnt_new > r_peak_count) begin
                    r_peak_bin    <= bin;
                    r_peak_count  <= cnt_new;
                    r_peak_sample <= r_sample;
                    o_peak_bin    <= bin;
                    o_peak_count  <= cnt_new;
                    o_peak_sample <= r_sample;
                end else begin
                    o_peak_bin    <= r_peak_bin;
                    o_peak_count  <= r_peak_count;
                    o_peak_sample <= r_peak_sample;
                end
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
